// ----- hdl/u8ufl_pkg.sv -----
// ----------------------------------------------------------------------------
// u8ufl_pkg
// Shared constants, types and helpers for the UNORM8 to R11G11B10 packer.
// ----------------------------------------------------------------------------
package u8ufl_pkg;

    localparam int CHAN_W    = 8;
    localparam int EXP_W     = 5;
    localparam int RG_FRAC_W = 6;
    localparam int B_FRAC_W  = 5;
    localparam int LZ_W      = 3;

    localparam logic [EXP_W-1:0]  EXP_ONE  = 5'd15;
    localparam logic [EXP_W-1:0]  EXP_TOP  = 5'd14;
    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    typedef struct packed {
        logic adv1;
        logic adv2;
        logic adv3;
    } pipe_ctrl_t;

    function automatic logic [LZ_W-1:0] lzc8(input logic [CHAN_W-1:0] c);
        logic [LZ_W-1:0] cnt;
        logic            found;
        cnt   = '0;
        found = 1'b0;
        for (int i = CHAN_W - 1; i >= 0; i--)
        begin
            if (!found && c[i])
            begin
                found = 1'b1;
                cnt   = LZ_W'(CHAN_W - 1 - i);
            end
        end
        return cnt;
    endfunction

endpackage

// ----- hdl/u8ufl_chan.sv -----
// ----------------------------------------------------------------------------
// u8ufl_chan
// Three-stage datapath for one channel: normalize, round, pack the field.
// ----------------------------------------------------------------------------
module u8ufl_chan #(
    parameter int FRAC_W = u8ufl_pkg::RG_FRAC_W
) (
    input  logic                                 clk,
    input  u8ufl_pkg::pipe_ctrl_t                ctrl,
    input  logic [u8ufl_pkg::CHAN_W-1:0]         c,
    output logic [u8ufl_pkg::EXP_W+FRAC_W-1:0]   field
);

    localparam int RND_W = FRAC_W + 2;

    logic [u8ufl_pkg::CHAN_W-1:0]        n_reg, n_next;
    logic [u8ufl_pkg::LZ_W-1:0]          lz_reg, lz_next;
    logic                                zero1_reg, zero1_next;
    logic                                full_reg, full_next;

    logic [u8ufl_pkg::EXP_W-1:0]         exp_reg, exp_next;
    logic [RND_W-1:0]                    rnd_reg, rnd_next;
    logic                                zero2_reg;

    logic [u8ufl_pkg::EXP_W+FRAC_W-1:0]  field_reg, field_next;
    logic                                ovf;
    logic [u8ufl_pkg::EXP_W-1:0]         exp_fin;
    logic [FRAC_W-1:0]                   frac_fin;

    always_comb
    begin
        lz_next    = u8ufl_pkg::lzc8(c);
        n_next     = c << lz_next;
        zero1_next = (c == '0);
        full_next  = (c == u8ufl_pkg::CHAN_MAX);
    end

    always_comb
    begin
        if (full_reg)
        begin
            exp_next = u8ufl_pkg::EXP_ONE;
            rnd_next = RND_W'(1) << FRAC_W;
        end
        else
        begin
            exp_next = u8ufl_pkg::EXP_TOP - u8ufl_pkg::EXP_W'(lz_reg);
            rnd_next = RND_W'(n_reg[u8ufl_pkg::CHAN_W-1:u8ufl_pkg::CHAN_W-1-FRAC_W])
                     + RND_W'(n_reg[u8ufl_pkg::CHAN_W-2-FRAC_W]);
        end
    end

    always_comb
    begin
        ovf      = rnd_reg[RND_W-1];
        exp_fin  = exp_reg + u8ufl_pkg::EXP_W'(ovf);
        frac_fin = ovf ? '0 : rnd_reg[FRAC_W-1:0];
        field_next = zero2_reg ? '0 : {exp_fin, frac_fin};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.adv1)
        begin
            n_reg     <= n_next;
            lz_reg    <= lz_next;
            zero1_reg <= zero1_next;
            full_reg  <= full_next;
        end
        if (ctrl.adv2)
        begin
            exp_reg   <= exp_next;
            rnd_reg   <= rnd_next;
            zero2_reg <= zero1_reg;
        end
        if (ctrl.adv3)
        begin
            field_reg <= field_next;
        end
    end

    assign field = field_reg;

endmodule

// ----- hdl/unorm8_to_r11g11b10_ufloat.sv -----
// ----------------------------------------------------------------------------
// unorm8_to_r11g11b10_ufloat
// Packs three UNORM8 channels into one R11G11B10 unsigned-float word.
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid, in_ready  | red[7:0], green[7:0], blue[7:0]
//   output  | out_valid, out_ready| packed_word[31:0] (R 10:0, G 21:11, B 31:22)
//
// out_valid rises once an accepted item has reached the pack register;
// one item per cycle while out_ready is held high.
// Three register stages (normalize, round, pack) each hold a valid bit.
// A stage advances when it is empty or the stage after it advances, so
// bubbles collapse and a stall at out_ready holds every item in place.
// Reset clears the valid bits only.
// ----------------------------------------------------------------------------
module unorm8_to_r11g11b10_ufloat (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [u8ufl_pkg::CHAN_W-1:0]  red,
    input  logic [u8ufl_pkg::CHAN_W-1:0]  green,
    input  logic [u8ufl_pkg::CHAN_W-1:0]  blue,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [31:0]                   packed_word
);

    localparam int RG_FIELD_W = u8ufl_pkg::EXP_W + u8ufl_pkg::RG_FRAC_W;
    localparam int B_FIELD_W  = u8ufl_pkg::EXP_W + u8ufl_pkg::B_FRAC_W;

    u8ufl_pkg::pipe_ctrl_t  ctrl;
    logic                   v1_reg, v1_next;
    logic                   v2_reg, v2_next;
    logic                   v3_reg, v3_next;

    logic [RG_FIELD_W-1:0]  r_field;
    logic [RG_FIELD_W-1:0]  g_field;
    logic [B_FIELD_W-1:0]   b_field;

    always_comb
    begin
        ctrl.adv3 = !v3_reg || out_ready;
        ctrl.adv2 = !v2_reg || ctrl.adv3;
        ctrl.adv1 = !v1_reg || ctrl.adv2;
        v1_next   = ctrl.adv1 ? in_valid : v1_reg;
        v2_next   = ctrl.adv2 ? v1_reg   : v2_reg;
        v3_next   = ctrl.adv3 ? v2_reg   : v3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    u8ufl_chan #(.FRAC_W(u8ufl_pkg::RG_FRAC_W)) u_red (
        .clk   (clk),
        .ctrl  (ctrl),
        .c     (red),
        .field (r_field)
    );

    u8ufl_chan #(.FRAC_W(u8ufl_pkg::RG_FRAC_W)) u_green (
        .clk   (clk),
        .ctrl  (ctrl),
        .c     (green),
        .field (g_field)
    );

    u8ufl_chan #(.FRAC_W(u8ufl_pkg::B_FRAC_W)) u_blue (
        .clk   (clk),
        .ctrl  (ctrl),
        .c     (blue),
        .field (b_field)
    );

    assign in_ready    = ctrl.adv1;
    assign out_valid   = v3_reg;
    assign packed_word = {b_field, g_field, r_field};

endmodule

// ----- hdl/u8ufl_checker.sv -----
// ----------------------------------------------------------------------------
// u8ufl_checker
// Port-level checks on the R11G11B10 packer, bound to the top level.
// ----------------------------------------------------------------------------
module u8ufl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] packed_word
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(packed_word))
        else $error("output item changed or dropped under stall");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output side is empty");

    a_one_exact: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (packed_word[10:6] != 5'd15 || packed_word[5:0] == 6'd0)
                   && (packed_word[21:17] != 5'd15 || packed_word[16:11] == 6'd0)
                   && (packed_word[31:27] != 5'd15 || packed_word[26:22] == 5'd0))
        else $error("field at exponent 15 exceeds 1.0");

    a_no_overrange: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !packed_word[10] && !packed_word[21] && !packed_word[31])
        else $error("field exponent above 15");

endmodule

bind unorm8_to_r11g11b10_ufloat u8ufl_checker u_u8ufl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .packed_word (packed_word)
);
